// ===== hw/rtl/cllh_pkg.sv =====
// Package for the command latency histogram: transaction types, status codes and sizes.
// Used by the front end, the back end and the top level; depends on nothing.
`default_nettype none
package cllh_pkg;
   localparam int PENDING_ENTRIES = 1024;
   localparam int COMMANDS = 64;
   localparam int SLOTS = 36;
   localparam int PEND_AW = $clog2(PENDING_ENTRIES);
   localparam int CMD_AW = $clog2(COMMANDS);
   localparam int SLOT_W = 6;
   localparam int HIST_DEPTH = COMMANDS * SLOTS;
   localparam int HIST_AW = $clog2(HIST_DEPTH);
   localparam int CLEAR_LEN = (HIST_DEPTH > PENDING_ENTRIES) ? HIST_DEPTH : PENDING_ENTRIES;
   localparam int CLR_W = $clog2(CLEAR_LEN + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int NS_PER_US = 1000;

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_FINISH = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [2:0] ST_DONE = 3'd0;
   localparam logic [2:0] ST_FILTERED = 3'd1;
   localparam logic [2:0] ST_NO_PENDING = 3'd2;
   localparam logic [2:0] ST_CMD_RANGE = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;
   localparam logic [2:0] ST_READ = 3'd5;

   typedef struct packed {
      logic [1:0] func;
      logic [63:0] thread_key;
      logic [63:0] time_ns;
      logic [31:0] cmd;
      logic [5:0] slot;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] bucket;
      logic [63:0] count;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic filtered;
   } job_type;
endpackage
`default_nettype wire

// ===== hw/rtl/cllh_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module cllh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input wire logic clock,
   input wire logic we,
   input wire logic [$clog2(DEPTH)-1:0] addr,
   input wire logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/cllh_front.sv =====
// Front end: takes request transactions, applies the process filter and queues jobs.
// Depends on cllh_pkg.
`default_nettype none
module cllh_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire cllh_pkg::req_type req_data,
   input wire logic [31:0] keep_pid,
   output logic job_valid,
   output cllh_pkg::job_type job_data,
   input wire logic job_take
);
   cllh_pkg::job_type q_ff [cllh_pkg::QUEUE_DEPTH];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;
   cllh_pkg::job_type job_new;

   assign req_stall = (cnt_ff == 2'(cllh_pkg::QUEUE_DEPTH));
   assign push = req_valid && !req_stall;
   assign job_valid = (cnt_ff != 2'd0);
   assign job_data = q_ff[rd_ptr_ff];

   always_comb begin
      job_new.req = req_data;
      job_new.filtered = (keep_pid != 32'd0) && (req_data.thread_key[63:32] != keep_pid);
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = job_take ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(job_take);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job_new;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/cllh_back.sv =====
// Back end: pending table search, latency bucketing and histogram update.
// Depends on cllh_pkg and cllh_ram.
`default_nettype none
module cllh_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic job_valid,
   input wire cllh_pkg::job_type job_data,
   output logic job_take,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output cllh_pkg::rsp_type rsp_data
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_SCAN_WAIT, S_HIT, S_WRITE, S_LOG,
      S_HRD, S_HRD_WAIT, S_HWR, S_RESP
   } state_type;

   localparam int PA = cllh_pkg::PEND_AW;
   localparam int HA = cllh_pkg::HIST_AW;
   localparam int CW = cllh_pkg::CLR_W;

   state_type state_ff;
   cllh_pkg::req_type cur_ff;
   logic [PA:0] idx_ff;
   logic [PA-1:0] hit_ff, free_ff;
   logic hit_found_ff, free_found_ff;
   logic [CW-1:0] clr_ff;
   logic [63:0] delta_ff;
   logic [cllh_pkg::CMD_AW-1:0] hcmd_ff;
   logic [5:0] bucket_ff;
   logic rsp_valid_ff;
   cllh_pkg::rsp_type rsp_ff;

   logic p_we;
   logic [PA-1:0] p_addr;
   logic [160:0] p_wdata, p_rdata;
   logic h_we;
   logic [HA-1:0] h_addr;
   logic [63:0] h_wdata, h_rdata;
   logic [HA-1:0] hist_index;
   logic [5:0] lg;

   cllh_ram #(.WIDTH(161), .DEPTH(cllh_pkg::PENDING_ENTRIES)) u_pend (
      .clock(clock), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
   );
   cllh_ram #(.WIDTH(64), .DEPTH(cllh_pkg::HIST_DEPTH)) u_hist (
      .clock(clock), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign job_take = (state_ff == S_IDLE) && job_valid && !rsp_valid_ff;

   always_comb begin
      hist_index = HA'(hcmd_ff) * HA'(cllh_pkg::SLOTS) + HA'(bucket_ff);
      if (state_ff == S_IDLE) begin
         hist_index = HA'(job_data.req.cmd[cllh_pkg::CMD_AW-1:0]) * HA'(cllh_pkg::SLOTS)
                      + HA'(job_data.req.slot);
      end
      lg = 6'd0;
      for (int k = 1; k < cllh_pkg::SLOTS; k++) begin
         if (delta_ff >= (64'(cllh_pkg::NS_PER_US) << k)) begin
            lg = 6'(k);
         end
      end
      p_we = (state_ff == S_WRITE)
             || (state_ff == S_CLEAR && clr_ff < CW'(cllh_pkg::PENDING_ENTRIES))
             || (state_ff == S_HIT && cur_ff.func == cllh_pkg::FUNC_FINISH && hit_found_ff);
      if (state_ff == S_CLEAR) begin
         p_addr = clr_ff[PA-1:0];
      end else if (state_ff == S_WRITE || state_ff == S_HIT) begin
         p_addr = hit_ff;
      end else begin
         p_addr = idx_ff[PA-1:0];
      end
      if (state_ff == S_CLEAR) begin
         p_wdata = '0;
      end else if (state_ff == S_HIT) begin
         p_wdata = {1'b0, p_rdata[159:0]};
      end else begin
         p_wdata = {1'b1, cur_ff.thread_key, cur_ff.time_ns, cur_ff.cmd};
      end
      h_we = (state_ff == S_CLEAR && clr_ff < CW'(cllh_pkg::HIST_DEPTH))
             || (state_ff == S_HWR);
      h_addr = (state_ff == S_CLEAR) ? clr_ff[HA-1:0] : hist_index;
      h_wdata = (state_ff == S_CLEAR) ? 64'd0 : h_rdata + 64'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + CW'(1);
               if (clr_ff == CW'(cllh_pkg::CLEAR_LEN - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (job_take) begin
                  cur_ff <= job_data.req;
                  idx_ff <= '0;
                  hit_found_ff <= 1'b0;
                  free_found_ff <= 1'b0;
                  rsp_ff.bucket <= '0;
                  rsp_ff.count <= '0;
                  case (job_data.req.func)
                     cllh_pkg::FUNC_START, cllh_pkg::FUNC_FINISH: begin
                        if (job_data.filtered) begin
                           rsp_ff.status <= cllh_pkg::ST_FILTERED;
                           state_ff <= S_RESP;
                        end else begin
                           rsp_ff.status <= cllh_pkg::ST_DONE;
                           state_ff <= S_SCAN;
                        end
                     end
                     cllh_pkg::FUNC_READ: begin
                        if (job_data.req.cmd >= 32'(cllh_pkg::COMMANDS)) begin
                           rsp_ff.status <= cllh_pkg::ST_CMD_RANGE;
                           state_ff <= S_RESP;
                        end else if (job_data.req.slot >= 6'(cllh_pkg::SLOTS)) begin
                           rsp_ff.status <= cllh_pkg::ST_READ;
                           state_ff <= S_RESP;
                        end else begin
                           rsp_ff.status <= cllh_pkg::ST_READ;
                           state_ff <= S_HRD;
                        end
                     end
                     default: begin
                        rsp_ff.status <= cllh_pkg::ST_DONE;
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               state_ff <= S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
               if (p_rdata[160] && p_rdata[159:96] == cur_ff.thread_key) begin
                  hit_ff <= idx_ff[PA-1:0];
                  hit_found_ff <= 1'b1;
                  state_ff <= S_HIT;
               end else begin
                  if (!p_rdata[160] && !free_found_ff) begin
                     free_ff <= idx_ff[PA-1:0];
                     free_found_ff <= 1'b1;
                  end
                  if (idx_ff == (PA+1)'(cllh_pkg::PENDING_ENTRIES - 1)) begin
                     state_ff <= S_HIT;
                  end else begin
                     idx_ff <= idx_ff + (PA+1)'(1);
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_HIT: begin
               if (cur_ff.func == cllh_pkg::FUNC_START) begin
                  if (hit_found_ff) begin
                     state_ff <= S_WRITE;
                  end else if (free_found_ff) begin
                     hit_ff <= free_ff;
                     state_ff <= S_WRITE;
                  end else begin
                     rsp_ff.status <= cllh_pkg::ST_FULL;
                     state_ff <= S_RESP;
                  end
               end else if (!hit_found_ff) begin
                  rsp_ff.status <= cllh_pkg::ST_NO_PENDING;
                  state_ff <= S_RESP;
               end else begin
                  if (p_rdata[31:0] >= 32'(cllh_pkg::COMMANDS)) begin
                     rsp_ff.status <= cllh_pkg::ST_CMD_RANGE;
                     state_ff <= S_RESP;
                  end else begin
                     hcmd_ff <= p_rdata[cllh_pkg::CMD_AW-1:0];
                     delta_ff <= cur_ff.time_ns - p_rdata[95:32];
                     state_ff <= S_LOG;
                  end
               end
            end
            S_WRITE: begin
               state_ff <= S_RESP;
            end
            S_LOG: begin
               bucket_ff <= lg;
               state_ff <= S_HRD;
            end
            S_HRD: begin
               state_ff <= S_HRD_WAIT;
            end
            S_HRD_WAIT: begin
               if (cur_ff.func == cllh_pkg::FUNC_READ) begin
                  rsp_ff.count <= h_rdata;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_HWR;
               end
            end
            S_HWR: begin
               rsp_ff.bucket <= bucket_ff;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (state_ff == S_IDLE && job_take && job_data.req.func == cllh_pkg::FUNC_READ) begin
         hcmd_ff <= job_data.req.cmd[cllh_pkg::CMD_AW-1:0];
         bucket_ff <= job_data.req.slot;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/command_latency_log2_histogram.sv =====
// Top level of the command latency histogram: filter register, front end and back end.
// Depends on cllh_pkg, cllh_front and cllh_back.
//
// Start and finish transactions search the 1024-entry pending table entry by entry, with a
// read state and a compare state per entry (single-port table RAM); a finish adds a
// compare of the elapsed time against the scaled bucket bounds and a histogram
// read-modify-write. After reset a clearing pass zeroes the histogram and the pending
// table before the first request is processed; requests still queue in the two-entry
// front queue.
`default_nettype none
module command_latency_log2_histogram (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire cllh_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output cllh_pkg::rsp_type rsp_data,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [31:0] csr_data
);
   logic [31:0] keep_pid_ff;
   logic job_valid, job_take;
   cllh_pkg::job_type job_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_pid_ff <= 32'd0;
      end else if (csr_valid) begin
         keep_pid_ff <= csr_data;
      end
   end

   cllh_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .keep_pid(keep_pid_ff), .job_valid(job_valid),
      .job_data(job_data), .job_take(job_take)
   );

   cllh_back u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job_data(job_data),
      .job_take(job_take), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire
